// ----- rtl/mdfs_pkg.sv -----
package mdfs_pkg;

    // default geometry
    localparam int GRID_ROWS_DEF   = 32;
    localparam int GRID_COLS_DEF   = 128;
    localparam int STACK_DEPTH_DEF = 4096;

    // word field widths
    localparam int OP_W   = 2;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int STAT_W = 3;
    localparam int LEN_W  = 13;
    localparam int CELL_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // register reset values
    localparam logic [ROW_W-1:0] START_ROW_RST = ROW_W'(1);
    localparam logic [COL_W-1:0] START_COL_RST = COL_W'(0);
    localparam logic [ROW_W-1:0] GOAL_ROW_RST  = ROW_W'(29);
    localparam logic [COL_W-1:0] GOAL_COL_RST  = COL_W'(79);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_STEP  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 3'd0,
        ST_ADVANCE   = 3'd1,
        ST_BACKTRACK = 3'd2,
        ST_GOAL      = 3'd3,
        ST_NO_ROUTE  = 3'd4,
        ST_FULL      = 3'd5,
        ST_ROUTE     = 3'd6,
        ST_END       = 3'd7
    } status_t;

    typedef enum logic [CELL_W-1:0] {
        CELL_WALL = 2'd0,
        CELL_OPEN = 2'd1,
        CELL_DEAD = 2'd2,
        CELL_PATH = 2'd3
    } cell_t;

    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ROW = 2'd0,
        CFG_START_COL = 2'd1,
        CFG_GOAL_ROW  = 2'd2,
        CFG_GOAL_COL  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TOP,
        S_PROBE,
        S_ADV1,
        S_ADV2,
        S_BT1,
        S_BT2,
        S_RD,
        S_EMIT
    } state_t;

endpackage

// ----- rtl/mdfs_cmd_if.sv -----
interface mdfs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [mdfs_pkg::OP_W-1:0]    op;
    logic [mdfs_pkg::ROW_W-1:0]   cell_row;
    logic [mdfs_pkg::COL_W-1:0]   cell_col;
    logic                         cell_open;

    modport source (output valid, op, cell_row, cell_col, cell_open, input ready);
    modport sink   (input valid, op, cell_row, cell_col, cell_open, output ready);
endinterface

// ----- rtl/mdfs_rsp_if.sv -----
interface mdfs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mdfs_pkg::STAT_W-1:0]  status;
    logic [mdfs_pkg::ROW_W-1:0]   pos_row;
    logic [mdfs_pkg::COL_W-1:0]   pos_col;
    logic [mdfs_pkg::LEN_W-1:0]   path_length;
    logic                         route_last;

    modport source (output valid, status, pos_row, pos_col, path_length, route_last,
                    input ready);
    modport sink   (input valid, status, pos_row, pos_col, path_length, route_last,
                    output ready);
endinterface

// ----- rtl/mdfs_ram.sv -----
module mdfs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/maze_dfs_path_walker.sv -----
// a word's path: load, start and an empty-stack step go straight to emit; a read passes
// S_RD, or goes straight to emit past the end; a step reads the top, emits on the goal, else
// probes, then advances (or emits when full) or pops; one word in flight, and the four
// neighbour probes share the single grid read port, one probe per cycle
// reset: async active low; then a clearing pass writes every grid cell as wall,
// all GRID_ROWS*GRID_COLS of them (4096 by default), during which no word is taken
module maze_dfs_path_walker #(
    parameter int GRID_ROWS   = mdfs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS   = mdfs_pkg::GRID_COLS_DEF,
    parameter int STACK_DEPTH = mdfs_pkg::STACK_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mdfs_cmd_if.sink                        cmd,
    mdfs_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [mdfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mdfs_pkg::CFG_DATA_W-1:0] cfg_data
);

    // geometry derived from the parameters
    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int GD = GRID_ROWS * GRID_COLS;
    localparam int GA = $clog2(GD);
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int EW = RW + CW;

    localparam logic [RW:0]    ROWS_X    = (RW + 1)'(GRID_ROWS);
    localparam logic [CW:0]    COLS_X    = (CW + 1)'(GRID_COLS);
    localparam logic [GA-1:0]  CLR_LAST  = GA'(GD - 1);
    localparam logic [2:0]     PROBE_END = 3'd4;

    // neighbour of a cell with its in-grid flag
    typedef struct packed {
        logic          inb;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
    } nbr_t;

    // one result word before it moves to the output register
    typedef struct packed {
        mdfs_pkg::status_t          status;
        logic [mdfs_pkg::ROW_W-1:0] row;
        logic [mdfs_pkg::COL_W-1:0] col;
        logic                       last;
    } res_t;

    // row-major cell address
    function automatic logic [GA-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
        return GA'(32'(r) * 32'(GRID_COLS) + 32'(c));
    endfunction

    // neighbour in one direction; cells off the grid come back with inb low
    function automatic nbr_t nbr_of(mdfs_pkg::dir_t d, logic [RW-1:0] r,
                                    logic [CW-1:0] c);
        logic [RW:0] r1;
        logic [CW:0] c1;
        nbr_t        n;
        r1    = {1'b0, r};
        c1    = {1'b0, c};
        n.inb = 1'b1;
        n.row = r;
        n.col = c;
        unique case (d)
            mdfs_pkg::DIR_DOWN:
            begin
                r1    = r1 + 1'b1;
                n.row = RW'(r1);
                n.inb = (r1 < ROWS_X);
            end
            mdfs_pkg::DIR_UP:
            begin
                n.row = r - 1'b1;
                n.inb = (r != '0);
            end
            mdfs_pkg::DIR_RIGHT:
            begin
                c1    = c1 + 1'b1;
                n.col = CW'(c1);
                n.inb = (c1 < COLS_X);
            end
            mdfs_pkg::DIR_LEFT:
            begin
                n.col = c - 1'b1;
                n.inb = (c != '0);
            end
        endcase
        return n;
    endfunction

    // control state
    mdfs_pkg::state_t state_reg, state_next;
    logic [TW-1:0]    top_reg, top_next;        // cells on the path stack
    logic [TW-1:0]    rp_reg, rp_next;          // route read pointer
    logic [GA-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [2:0]       issue_k_reg, issue_k_next; // next probe direction to read
    logic             chk_vld_reg, chk_vld_next; // a probe read is in flight
    mdfs_pkg::dir_t   chk_k_reg, chk_k_next;     // direction of that probe
    logic             out_valid_reg, out_valid_next;

    // configuration registers
    logic [mdfs_pkg::ROW_W-1:0] start_row_reg, goal_row_reg;
    logic [mdfs_pkg::COL_W-1:0] start_col_reg, goal_col_reg;

    // payload registers
    logic [RW-1:0]              cur_row_reg, cur_row_next;
    logic [CW-1:0]              cur_col_reg, cur_col_next;
    logic [RW-1:0]              nbr_row_reg, nbr_row_next;
    logic [CW-1:0]              nbr_col_reg, nbr_col_next;
    res_t                       res_reg, res_next;
    res_t                       out_reg, out_next;
    logic [mdfs_pkg::LEN_W-1:0] out_len_reg, out_len_next;

    // memory ports
    logic          gr_we;
    logic [GA-1:0] gr_waddr, gr_raddr;
    logic [1:0]    gr_wdata, gr_rdata;
    logic          st_we;
    logic [SA-1:0] st_waddr, st_raddr;
    logic [EW-1:0] st_wdata, st_rdata;

    // shared decode
    mdfs_pkg::op_t cmd_op;
    logic          cmd_fire;
    logic          load_inb;
    logic          start_inb;
    logic          top_empty;
    logic          route_avail;
    logic          stack_full;
    logic [RW-1:0] st_rd_row;
    logic [CW-1:0] st_rd_col;
    logic          goal_hit;
    nbr_t          iss_nbr;
    nbr_t          chk_nbr;
    logic          probe_hit;

    // grid: 2-bit cell codes, row-major
    mdfs_ram #(
        .WIDTH (mdfs_pkg::CELL_W),
        .DEPTH (GD)
    ) u_grid_ram (
        .clk   (clk),
        .we    (gr_we),
        .waddr (gr_waddr),
        .wdata (gr_wdata),
        .raddr (gr_raddr),
        .rdata (gr_rdata)
    );

    // path stack: {row, col} per entry, only entries below the top are read
    mdfs_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign cmd_op      = mdfs_pkg::op_t'(cmd.op);
    assign cmd.ready   = (state_reg == mdfs_pkg::S_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign load_inb    = (32'(cmd.cell_row) < GRID_ROWS) && (32'(cmd.cell_col) < GRID_COLS);
    assign start_inb   = (32'(start_row_reg) < GRID_ROWS) && (32'(start_col_reg) < GRID_COLS);
    assign top_empty   = (top_reg == '0);
    assign route_avail = (rp_reg < top_reg);
    assign stack_full  = (32'(top_reg) >= STACK_DEPTH);

    // stack read data is registered and arrives in the cycle after the address
    assign st_rd_row = st_rdata[EW-1:CW];
    assign st_rd_col = st_rdata[CW-1:0];
    assign goal_hit  = (32'(st_rd_row) == 32'(goal_row_reg))
                    && (32'(st_rd_col) == 32'(goal_col_reg));

    // probe pipeline: read issued for issue_k, data checked for chk_k in the cycle after
    assign iss_nbr   = nbr_of(mdfs_pkg::dir_t'(issue_k_reg[1:0]), cur_row_reg, cur_col_reg);
    assign chk_nbr   = nbr_of(chk_k_reg, cur_row_reg, cur_col_reg);
    assign probe_hit = chk_vld_reg && chk_nbr.inb && (gr_rdata == mdfs_pkg::CELL_OPEN);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mdfs_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = mdfs_pkg::S_IDLE;
                end
            end
            mdfs_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd_op) inside
                        mdfs_pkg::OP_LOAD, mdfs_pkg::OP_START:
                            state_next = mdfs_pkg::S_EMIT;
                        mdfs_pkg::OP_STEP:
                            state_next = top_empty ? mdfs_pkg::S_EMIT : mdfs_pkg::S_TOP;
                        mdfs_pkg::OP_READ:
                            state_next = route_avail ? mdfs_pkg::S_RD : mdfs_pkg::S_EMIT;
                    endcase
                end
            end
            mdfs_pkg::S_TOP:
            begin
                state_next = goal_hit ? mdfs_pkg::S_EMIT : mdfs_pkg::S_PROBE;
            end
            mdfs_pkg::S_PROBE:
            begin
                if (probe_hit)
                begin
                    state_next = stack_full ? mdfs_pkg::S_EMIT : mdfs_pkg::S_ADV1;
                end
                else if (issue_k_reg == PROBE_END)
                begin
                    state_next = mdfs_pkg::S_BT1;
                end
            end
            mdfs_pkg::S_ADV1:
            begin
                state_next = mdfs_pkg::S_ADV2;
            end
            mdfs_pkg::S_ADV2:
            begin
                state_next = mdfs_pkg::S_EMIT;
            end
            mdfs_pkg::S_BT1:
            begin
                state_next = (top_reg == TW'(1)) ? mdfs_pkg::S_EMIT : mdfs_pkg::S_BT2;
            end
            mdfs_pkg::S_BT2:
            begin
                state_next = mdfs_pkg::S_EMIT;
            end
            mdfs_pkg::S_RD:
            begin
                state_next = mdfs_pkg::S_EMIT;
            end
            mdfs_pkg::S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = mdfs_pkg::S_IDLE;
                end
            end
        endcase
    end

    // memory controls and datapath
    always_comb
    begin
        top_next       = top_reg;
        rp_next        = rp_reg;
        clr_cnt_next   = clr_cnt_reg;
        issue_k_next   = issue_k_reg;
        chk_vld_next   = chk_vld_reg;
        chk_k_next     = chk_k_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        nbr_row_next   = nbr_row_reg;
        nbr_col_next   = nbr_col_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_len_next   = out_len_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        gr_we    = 1'b0;
        gr_waddr = '0;
        gr_wdata = mdfs_pkg::CELL_WALL;
        gr_raddr = '0;
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        st_raddr = '0;

        unique case (state_reg)
            mdfs_pkg::S_CLEAR:
            begin
                // sweep the grid to wall after reset
                gr_we        = 1'b1;
                gr_waddr     = clr_cnt_reg;
                gr_wdata     = mdfs_pkg::CELL_WALL;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            mdfs_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd_op) inside
                        mdfs_pkg::OP_LOAD:
                        begin
                            // cells off the grid are dropped, the word still answers
                            gr_we    = load_inb;
                            gr_waddr = cell_addr(RW'(cmd.cell_row), CW'(cmd.cell_col));
                            gr_wdata = cmd.cell_open ? mdfs_pkg::CELL_OPEN
                                                     : mdfs_pkg::CELL_WALL;
                            res_next = '{mdfs_pkg::ST_DONE, cmd.cell_row, cmd.cell_col, 1'b0};
                        end
                        mdfs_pkg::OP_START:
                        begin
                            rp_next = '0;
                            if (start_inb)
                            begin
                                st_we    = 1'b1;
                                st_waddr = '0;
                                st_wdata = {RW'(start_row_reg), CW'(start_col_reg)};
                                top_next = TW'(1);
                                res_next = '{mdfs_pkg::ST_DONE, start_row_reg,
                                             start_col_reg, 1'b0};
                            end
                            else
                            begin
                                top_next = '0;
                                res_next = '{mdfs_pkg::ST_NO_ROUTE, '0, '0, 1'b0};
                            end
                        end
                        mdfs_pkg::OP_STEP:
                        begin
                            // fetch the stack top; empty stack answers no route
                            st_raddr = SA'(top_reg - 1'b1);
                            res_next = '{mdfs_pkg::ST_NO_ROUTE, '0, '0, 1'b0};
                        end
                        mdfs_pkg::OP_READ:
                        begin
                            st_raddr = SA'(rp_reg);
                            res_next = '{mdfs_pkg::ST_END, '0, '0, 1'b0};
                        end
                    endcase
                end
            end
            mdfs_pkg::S_TOP:
            begin
                cur_row_next = st_rd_row;
                cur_col_next = st_rd_col;
                issue_k_next = '0;
                chk_vld_next = 1'b0;
                res_next     = '{mdfs_pkg::ST_GOAL, mdfs_pkg::ROW_W'(st_rd_row),
                                 mdfs_pkg::COL_W'(st_rd_col), 1'b0};
            end
            mdfs_pkg::S_PROBE:
            begin
                // probe order down, up, right, left
                gr_raddr = cell_addr(iss_nbr.row, iss_nbr.col);
                if (issue_k_reg != PROBE_END)
                begin
                    issue_k_next = issue_k_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_k_next   = mdfs_pkg::dir_t'(issue_k_reg[1:0]);
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                nbr_row_next = chk_nbr.row;
                nbr_col_next = chk_nbr.col;
                res_next     = '{mdfs_pkg::ST_FULL, mdfs_pkg::ROW_W'(cur_row_reg),
                                 mdfs_pkg::COL_W'(cur_col_reg), 1'b0};
            end
            mdfs_pkg::S_ADV1:
            begin
                // push the neighbour and leave the current cell dead
                st_we    = 1'b1;
                st_waddr = SA'(top_reg);
                st_wdata = {nbr_row_reg, nbr_col_reg};
                top_next = top_reg + 1'b1;
                gr_we    = 1'b1;
                gr_waddr = cell_addr(cur_row_reg, cur_col_reg);
                gr_wdata = mdfs_pkg::CELL_DEAD;
            end
            mdfs_pkg::S_ADV2:
            begin
                gr_we    = 1'b1;
                gr_waddr = cell_addr(nbr_row_reg, nbr_col_reg);
                gr_wdata = mdfs_pkg::CELL_PATH;
                res_next = '{mdfs_pkg::ST_ADVANCE, mdfs_pkg::ROW_W'(nbr_row_reg),
                             mdfs_pkg::COL_W'(nbr_col_reg), 1'b0};
            end
            mdfs_pkg::S_BT1:
            begin
                // pop; the entry below becomes the new top
                gr_we    = 1'b1;
                gr_waddr = cell_addr(cur_row_reg, cur_col_reg);
                gr_wdata = mdfs_pkg::CELL_DEAD;
                top_next = top_reg - 1'b1;
                st_raddr = SA'(top_reg - TW'(2));
                res_next = '{mdfs_pkg::ST_NO_ROUTE, '0, '0, 1'b0};
            end
            mdfs_pkg::S_BT2:
            begin
                gr_we    = 1'b1;
                gr_waddr = cell_addr(st_rd_row, st_rd_col);
                gr_wdata = mdfs_pkg::CELL_PATH;
                res_next = '{mdfs_pkg::ST_BACKTRACK, mdfs_pkg::ROW_W'(st_rd_row),
                             mdfs_pkg::COL_W'(st_rd_col), 1'b0};
            end
            mdfs_pkg::S_RD:
            begin
                rp_next  = rp_reg + 1'b1;
                res_next = '{mdfs_pkg::ST_ROUTE, mdfs_pkg::ROW_W'(st_rd_row),
                             mdfs_pkg::COL_W'(st_rd_col), (rp_reg + 1'b1 == top_reg)};
            end
            mdfs_pkg::S_EMIT:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_len_next   = mdfs_pkg::LEN_W'(top_reg);
                    out_valid_next = 1'b1;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mdfs_pkg::S_CLEAR;
            top_reg       <= '0;
            rp_reg        <= '0;
            clr_cnt_reg   <= '0;
            issue_k_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            chk_k_reg     <= mdfs_pkg::DIR_DOWN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            rp_reg        <= rp_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_k_reg   <= issue_k_next;
            chk_vld_reg   <= chk_vld_next;
            chk_k_reg     <= chk_k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers; the user must write them only while the walker is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= mdfs_pkg::START_ROW_RST;
            start_col_reg <= mdfs_pkg::START_COL_RST;
            goal_row_reg  <= mdfs_pkg::GOAL_ROW_RST;
            goal_col_reg  <= mdfs_pkg::GOAL_COL_RST;
        end
        else if (cfg_we)
        begin
            unique case (mdfs_pkg::cfg_idx_t'(cfg_index))
                mdfs_pkg::CFG_START_ROW: start_row_reg <= mdfs_pkg::ROW_W'(cfg_data);
                mdfs_pkg::CFG_START_COL: start_col_reg <= mdfs_pkg::COL_W'(cfg_data);
                mdfs_pkg::CFG_GOAL_ROW:  goal_row_reg  <= mdfs_pkg::ROW_W'(cfg_data);
                mdfs_pkg::CFG_GOAL_COL:  goal_col_reg  <= mdfs_pkg::COL_W'(cfg_data);
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_row_reg <= cur_row_next;
        cur_col_reg <= cur_col_next;
        nbr_row_reg <= nbr_row_next;
        nbr_col_reg <= nbr_col_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        out_len_reg <= out_len_next;
    end

    // result port
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.pos_row     = out_reg.row;
    assign rsp.pos_col     = out_reg.col;
    assign rsp.path_length = out_len_reg;
    assign rsp.route_last  = out_reg.last;

`ifndef SYNTHESIS
    // stack never grows past its depth
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(STACK_DEPTH))
        else $error("path stack top beyond depth");

    // the stack moves one entry at a time, except a start that resets it
    a_top_step: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg != $past(top_reg)) |->
            (top_reg == $past(top_reg) + 1'b1) || (top_reg == $past(top_reg) - 1'b1)
            || (top_reg <= TW'(1)))
        else $error("path stack top jumped");

    // a new result only comes out of the emit state
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mdfs_pkg::S_EMIT))
        else $error("result raised outside emit");

    // goal reports always carry a non-empty path
    a_goal_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == mdfs_pkg::ST_GOAL)) |-> (rsp.path_length != '0))
        else $error("goal reported with empty path");
`endif

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdfs_pkg::*;

    localparam int GRID_CELLS     = GRID_ROWS_DEF * GRID_COLS_DEF;
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 20000;  // covers the clearing pass after reset
    localparam int STEP_CAP       = 80;
    localparam int MAX_REPORTS    = 10;

    // one result word as the block presents it
    typedef struct packed {
        status_t              status;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [LEN_W-1:0]     len;
        logic                 last;
    } walk_res_t;

    // tracks the maze, the path stack and the registers, and holds the
    // result words still due from the block
    class dfs_walk_board;
        cell_t                grid [GRID_CELLS];
        logic [ROW_W-1:0]     stk_row [STACK_DEPTH_DEF];
        logic [COL_W-1:0]     stk_col [STACK_DEPTH_DEF];
        int unsigned          depth;
        int unsigned          rd_ptr;
        logic [ROW_W-1:0]     start_r;
        logic [COL_W-1:0]     start_c;
        logic [ROW_W-1:0]     goal_r;
        logic [COL_W-1:0]     goal_c;
        walk_res_t            due_replies [$];
        int unsigned          n_checked;
        int unsigned          n_errors;
        int unsigned          seen [8];

        function new();
            foreach (grid[i])
                grid[i] = CELL_WALL;
            foreach (seen[i])
                seen[i] = 0;
            depth     = 0;
            rd_ptr    = 0;
            start_r   = START_ROW_RST;
            start_c   = START_COL_RST;
            goal_r    = GOAL_ROW_RST;
            goal_c    = GOAL_COL_RST;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_START_ROW: start_r = data[ROW_W-1:0];
                CFG_START_COL: start_c = data[COL_W-1:0];
                CFG_GOAL_ROW:  goal_r  = data[ROW_W-1:0];
                default:       goal_c  = data[COL_W-1:0];
            endcase
        endfunction

        function bit on_grid(int r, int c);
            return r >= 0 && c >= 0 && r < GRID_ROWS_DEF && c < GRID_COLS_DEF;
        endfunction

        // outside the grid reads as wall
        function cell_t cell_at(int r, int c);
            if (!on_grid(r, c))
                return CELL_WALL;
            return grid[r * GRID_COLS_DEF + c];
        endfunction

        function void cell_put(int r, int c, cell_t v);
            if (on_grid(r, c))
                grid[r * GRID_COLS_DEF + c] = v;
        endfunction

        function walk_res_t take_step();
            walk_res_t res;
            int        r;
            int        c;
            int        nr;
            int        nc;
            int        k;
            bit        moved;
            res   = '0;
            moved = 1'b0;
            if (depth == 0)
            begin
                res.status = ST_NO_ROUTE;
                return res;
            end
            r = stk_row[depth-1];
            c = stk_col[depth-1];
            if (r == goal_r && c == goal_c)
            begin
                res.status = ST_GOAL;
                res.row    = ROW_W'(r);
                res.col    = COL_W'(c);
                return res;
            end
            for (k = 0; k < 4; k++)
            begin
                nr = r;
                nc = c;
                case (dir_t'(k))
                    DIR_DOWN:  nr = r + 1;
                    DIR_UP:    nr = r - 1;
                    DIR_RIGHT: nc = c + 1;
                    default:   nc = c - 1;
                endcase
                if (!moved && cell_at(nr, nc) == CELL_OPEN)
                begin
                    moved = 1'b1;
                    if (depth >= STACK_DEPTH_DEF)
                    begin
                        res.status = ST_FULL;
                        res.row    = ROW_W'(r);
                        res.col    = COL_W'(c);
                    end
                    else
                    begin
                        stk_row[depth] = ROW_W'(nr);
                        stk_col[depth] = COL_W'(nc);
                        depth++;
                        cell_put(r, c, CELL_DEAD);
                        cell_put(nr, nc, CELL_PATH);
                        res.status = ST_ADVANCE;
                        res.row    = ROW_W'(nr);
                        res.col    = COL_W'(nc);
                    end
                end
            end
            if (moved)
                return res;
            // dead end: retire the top and fall back one cell
            cell_put(r, c, CELL_DEAD);
            depth--;
            if (depth == 0)
            begin
                res.status = ST_NO_ROUTE;
                return res;
            end
            r = stk_row[depth-1];
            c = stk_col[depth-1];
            cell_put(r, c, CELL_PATH);
            res.status = ST_BACKTRACK;
            res.row    = ROW_W'(r);
            res.col    = COL_W'(c);
            return res;
        endfunction

        function walk_res_t predict_word(op_t op, logic [ROW_W-1:0] row,
                                         logic [COL_W-1:0] col, logic is_open);
            walk_res_t   res;
            int unsigned p;
            res = '0;
            case (op)
                OP_LOAD:
                begin
                    cell_put(row, col, is_open ? CELL_OPEN : CELL_WALL);
                    res.status = ST_DONE;
                    res.row    = row;
                    res.col    = col;
                end
                OP_START:
                begin
                    depth  = 0;
                    rd_ptr = 0;
                    if (!on_grid(start_r, start_c))
                        res.status = ST_NO_ROUTE;
                    else
                    begin
                        stk_row[0] = start_r;
                        stk_col[0] = start_c;
                        depth      = 1;
                        res.status = ST_DONE;
                        res.row    = start_r;
                        res.col    = start_c;
                    end
                end
                OP_STEP:
                    res = take_step();
                default:
                begin
                    if (rd_ptr < depth)
                    begin
                        p = rd_ptr;
                        rd_ptr++;
                        res.status = ST_ROUTE;
                        res.row    = stk_row[p];
                        res.col    = stk_col[p];
                        res.last   = (p + 1 == depth);
                    end
                    else
                        res.status = ST_END;
                end
            endcase
            res.len = LEN_W'(depth);
            due_replies.push_back(res);
            return res;
        endfunction

        function void check_result(walk_res_t got);
            walk_res_t want;
            bit        bad;
            if (due_replies.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("tb: unexpected result status %0d row %0d col %0d len %0d",
                             got.status, got.row, got.col, got.len);
                return;
            end
            want = due_replies.pop_front();
            seen[int'(want.status)]++;
            n_checked++;
            bad = (got.status !== want.status) || (got.row !== want.row) ||
                  (got.col !== want.col) || (got.len !== want.len) ||
                  (got.last !== want.last);
            if (bad)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display({"tb: result %0d mismatch: want st %0d r %0d c %0d len %0d",
                              " last %0d, got st %0d r %0d c %0d len %0d last %0d"},
                             n_checked, want.status, want.row, want.col, want.len,
                             want.last, got.status, got.row, got.col, got.len, got.last);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mdfs_cmd_if cmd ();
    mdfs_rsp_if rsp ();

    dfs_walk_board board;

    // idling knobs, in percent per cycle
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 1'b0;

    int unsigned words_in   = 0;
    int unsigned cfg_writes = 0;

    maze_dfs_path_walker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : sink_side
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor: every accepted result word goes to the board
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            board.check_result(walk_res_t'({rsp.status, rsp.pos_row, rsp.pos_col,
                                            rsp.path_length, rsp.route_last}));
    end

    // watchdog: ends the run when no word moves on either side for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // offer one command word, with random idle cycles ahead of it, and wait
    // for the handshake; valid stays high so back-to-back words need no gap
    task automatic send_word(input op_t op, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic is_open,
                             output walk_res_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.op        <= op;
        cmd.cell_row  <= row;
        cmd.cell_col  <= col;
        cmd.cell_open <= is_open;
        do
            @(posedge clk);
        while (!cmd.ready);
        res = board.predict_word(op, row, col, is_open);
        words_in++;
    endtask

    // any op, any field values
    task automatic send_noise();
        walk_res_t res;
        send_word(op_t'($urandom_range(3)), ROW_W'($urandom), COL_W'($urandom),
                  1'($urandom), res);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(99) < 8)
            send_noise();
    endtask

    // stop offering, wait out every due result, then let the block settle
    task automatic drain();
        cmd.valid <= 1'b0;
        while (board.due_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
        cfg_writes++;
    endtask

    // write all four registers back to back; row words get random upper bits
    task automatic set_walk(input logic [ROW_W-1:0] s_row, input logic [COL_W-1:0] s_col,
                            input logic [ROW_W-1:0] g_row, input logic [COL_W-1:0] g_col);
        logic [CFG_DATA_W-1:0] row_word;
        row_word = CFG_DATA_W'($urandom);
        row_word[ROW_W-1:0] = s_row;
        write_reg(CFG_START_ROW, row_word);
        write_reg(CFG_START_COL, CFG_DATA_W'(s_col));
        row_word = CFG_DATA_W'($urandom);
        row_word[ROW_W-1:0] = g_row;
        write_reg(CFG_GOAL_ROW, row_word);
        write_reg(CFG_GOAL_COL, CFG_DATA_W'(g_col));
        cfg_we <= 1'b0;
    endtask

    // one walk: carve a small random block of cells, often against the grid
    // border, start inside it, step until the walk ends, then read the route
    task automatic walk_episode();
        walk_res_t res;
        int        h;
        int        w;
        int        r0;
        int        c0;
        int        sr;
        int        sc;
        int        gr;
        int        gc;
        int        i;
        int        j;
        int        n;
        h  = $urandom_range(2, 6);
        w  = $urandom_range(2, 7);
        r0 = $urandom_range(0, GRID_ROWS_DEF - h);
        c0 = $urandom_range(0, GRID_COLS_DEF - w);
        case ($urandom_range(3))
            0:       r0 = 0;
            1:       r0 = GRID_ROWS_DEF - h;
            default: ;
        endcase
        case ($urandom_range(3))
            0:       c0 = 0;
            1:       c0 = GRID_COLS_DEF - w;
            default: ;
        endcase
        sr = r0 + $urandom_range(0, h - 1);
        sc = c0 + $urandom_range(0, w - 1);
        if ($urandom_range(9) == 0)
        begin
            // goal anywhere, mostly unreachable
            gr = $urandom_range(0, GRID_ROWS_DEF - 1);
            gc = $urandom_range(0, GRID_COLS_DEF - 1);
        end
        else
        begin
            gr = r0 + $urandom_range(0, h - 1);
            gc = c0 + $urandom_range(0, w - 1);
        end

        // registers only change while nothing is in flight
        drain();
        set_walk(ROW_W'(sr), COL_W'(sc), ROW_W'(gr), COL_W'(gc));

        // about 70% open cells
        for (i = 0; i < h; i++)
            for (j = 0; j < w; j++)
            begin
                maybe_noise();
                send_word(OP_LOAD, ROW_W'(r0 + i), COL_W'(c0 + j),
                          ($urandom_range(9) < 7), res);
            end

        // now and then skip the start and step on whatever stack is left
        if ($urandom_range(7) != 0)
            send_word(OP_START, ROW_W'($urandom), COL_W'($urandom), 1'($urandom), res);

        for (n = 0; n < STEP_CAP; n++)
        begin
            maybe_noise();
            send_word(OP_STEP, ROW_W'($urandom), COL_W'($urandom), 1'($urandom), res);
            if (res.status inside {ST_GOAL, ST_NO_ROUTE, ST_FULL})
                break;
        end

        // read the route out to one past its end
        n = 0;
        do
        begin
            maybe_noise();
            send_word(OP_READ, ROW_W'($urandom), COL_W'($urandom), 1'($urandom), res);
            n++;
        end
        while (res.status == ST_ROUTE && n < 200);

        // a start rewinds the read pointer
        if ($urandom_range(3) == 0)
        begin
            send_word(OP_START, ROW_W'($urandom), COL_W'($urandom), 1'($urandom), res);
            send_word(OP_READ, ROW_W'($urandom), COL_W'($urandom), 1'($urandom), res);
            send_word(OP_READ, ROW_W'($urandom), COL_W'($urandom), 1'($urandom), res);
        end
    endtask

    initial
    begin : main
        walk_res_t   res;
        int unsigned target;
        int          p;
        int unsigned send_mix [4];
        int unsigned recv_mix [4];

        send_mix = '{0, 50, 0, 28};
        recv_mix = '{0, 0, 50, 28};

        board = new();
        rst_n         = 1'b0;
        cmd.valid     = 1'b0;
        cmd.op        = OP_LOAD;
        cmd.cell_row  = '0;
        cmd.cell_col  = '0;
        cmd.cell_open = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START_ROW;
        cfg_data      = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, registers at reset values: start (1,0)
        send_word(OP_STEP, '0, '0, 1'b0, res);                      // empty stack
        send_word(OP_READ, '0, '0, 1'b0, res);                      // nothing to read
        send_word(OP_LOAD, ROW_W'(31), COL_W'(127), 1'b1, res);     // far corner open
        send_word(OP_LOAD, ROW_W'(31), COL_W'(127), 1'b0, res);     // and back to wall
        send_word(OP_LOAD, '0, '0, 1'b1, res);
        send_word(OP_LOAD, ROW_W'(1), COL_W'(1), 1'b1, res);
        send_word(OP_START, '0, '0, 1'b0, res);
        send_word(OP_STEP, '0, '0, 1'b0, res);                      // up into (0,0)
        send_word(OP_STEP, '0, '0, 1'b0, res);                      // boxed in, back off
        send_word(OP_STEP, '0, '0, 1'b0, res);                      // right into (1,1)
        send_word(OP_READ, '0, '0, 1'b0, res);
        send_word(OP_READ, '0, '0, 1'b0, res);                      // last route cell
        send_word(OP_READ, '0, '0, 1'b0, res);                      // past the top
        send_word(OP_STEP, '0, '0, 1'b0, res);
        send_word(OP_STEP, '0, '0, 1'b0, res);                      // pops the start cell
        send_word(OP_STEP, '0, '0, 1'b0, res);

        // start on the goal, in the corner
        drain();
        set_walk(ROW_W'(31), COL_W'(127), ROW_W'(31), COL_W'(127));
        send_word(OP_START, '0, '0, 1'b0, res);
        send_word(OP_STEP, '0, '0, 1'b0, res);

        // corner start, one move left reaches the goal
        drain();
        set_walk(ROW_W'(31), COL_W'(127), ROW_W'(31), COL_W'(126));
        send_word(OP_LOAD, ROW_W'(31), COL_W'(126), 1'b1, res);
        send_word(OP_START, '0, '0, 1'b0, res);
        send_word(OP_STEP, '0, '0, 1'b0, res);
        send_word(OP_STEP, '0, '0, 1'b0, res);
        send_word(OP_READ, '0, '0, 1'b0, res);
        send_word(OP_READ, '0, '0, 1'b0, res);
        send_word(OP_READ, '0, '0, 1'b0, res);

        // random walks under four idling mixes
        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_mix[p];
            recv_stall_pct = recv_mix[p];
            target = words_in + 340;
            if (p == 1 || p == 3)
            begin
                // receiver holds off while words keep coming, the input backs up
                drain();
                hold_req = 1'b1;
                repeat (24) send_noise();
            end
            while (words_in < target)
                walk_episode();
        end

        // wait out every due result and a little more
        drain();

        if (board.due_replies.size() != 0)
        begin
            board.n_errors++;
            $display("tb: %0d results never arrived", board.due_replies.size());
        end

        $display("tb: %0d words sent, %0d results checked, %0d register writes",
                 words_in, board.n_checked, cfg_writes);
        $display("tb: advance %0d, backtrack %0d, goal %0d, no route %0d, full %0d",
                 board.seen[ST_ADVANCE], board.seen[ST_BACKTRACK], board.seen[ST_GOAL],
                 board.seen[ST_NO_ROUTE], board.seen[ST_FULL]);
        $display("tb: route %0d, end %0d, mismatches %0d",
                 board.seen[ST_ROUTE], board.seen[ST_END], board.n_errors);
        if (board.n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mdfs_pkg.sv
rtl/mdfs_cmd_if.sv
rtl/mdfs_rsp_if.sv
rtl/mdfs_ram.sv
rtl/maze_dfs_path_walker.sv
tb/sv/tb.sv
